// ----- rtl/trqs_pkg.sv -----
// Shared types, codes and sizes of the thread ready queue scheduler.
package trqs_pkg;

	localparam int MAX_THREADS = 16;
	localparam int ID_W        = 4;
	localparam int ADDR_W      = $clog2(MAX_THREADS);
	localparam int LEN_W       = $clog2(MAX_THREADS);

	typedef logic [ID_W-1:0]   tid_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		REQ_CREATE  = 2'd0,
		REQ_YIELD   = 2'd1,
		REQ_DESTROY = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		KIND_NAMED = 2'd0,
		KIND_ANY   = 2'd1,
		KIND_SELF  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NONE    = 2'd1,
		ST_INVALID = 2'd2,
		ST_NOMORE  = 2'd3
	} status_t;

	// Decoded request, handed from the decoder to the sequencer.
	typedef struct packed {
		logic    imm;         // finished without touching the queue
		status_t imm_status;
		tid_t    imm_result;
		logic    create;      // scan for taken ids, then append
		logic    match_head;  // remove entry 0 instead of a named id
		logic    app_cur;     // running id goes to the tail
		logic    set_cur;     // removed id becomes running
		logic    res_cur;     // result is the old running id
	} op_t;

endpackage

// ----- rtl/trqs_decode.sv -----
// Request decoder: classifies a request against queue length and running id.
module trqs_decode (
	input  logic [1:0]          req_type,
	input  logic [1:0]          target_kind,
	input  trqs_pkg::tid_t      target_tid,
	input  trqs_pkg::len_t      len,
	input  trqs_pkg::tid_t      cur,
	output trqs_pkg::op_t       op
);

	logic known;

	assign known = (req_type inside {trqs_pkg::REQ_YIELD, trqs_pkg::REQ_DESTROY})
		&& (target_kind inside {trqs_pkg::KIND_NAMED, trqs_pkg::KIND_ANY,
		trqs_pkg::KIND_SELF});

	always_comb begin
		op            = '0;
		op.imm_status = trqs_pkg::ST_OK;
		if (req_type == trqs_pkg::REQ_CREATE) begin
			if (len >= trqs_pkg::len_t'(trqs_pkg::MAX_THREADS - 1)) begin
				op.imm        = 1'b1;
				op.imm_status = trqs_pkg::ST_NOMORE;
			end else begin
				op.create = 1'b1;
			end
		end else if (!known) begin
			op.imm        = 1'b1;
			op.imm_status = trqs_pkg::ST_INVALID;
		end else if (target_kind != trqs_pkg::KIND_NAMED && len == '0) begin
			op.imm        = 1'b1;
			op.imm_status = trqs_pkg::ST_NONE;
		end else if (req_type == trqs_pkg::REQ_YIELD) begin
			if (target_kind == trqs_pkg::KIND_SELF
				|| (target_kind == trqs_pkg::KIND_NAMED && target_tid == cur)) begin
				op.imm        = 1'b1;
				op.imm_result = cur;
			end else begin
				op.match_head = (target_kind == trqs_pkg::KIND_ANY);
				op.app_cur    = 1'b1;
				op.set_cur    = 1'b1;
			end
		end else begin
			// destroy
			op.match_head = (target_kind != trqs_pkg::KIND_NAMED);
			op.set_cur    = (target_kind == trqs_pkg::KIND_SELF);
			op.res_cur    = (target_kind == trqs_pkg::KIND_SELF);
		end
	end

endmodule

// ----- rtl/trqs_pick.sv -----
// Lowest free thread id from 1 upward, 0 when every id from 1 upward is taken.
module trqs_pick (
	input  logic [trqs_pkg::MAX_THREADS-1:0] taken,
	output trqs_pkg::tid_t                   pick
);

	always_comb begin
		pick = '0;
		for (int i = trqs_pkg::MAX_THREADS - 1; i >= 1; i--) begin
			if (!taken[i]) begin
				pick = trqs_pkg::tid_t'(i);
			end
		end
	end

endmodule

// ----- rtl/thread_ready_queue_scheduler.sv -----
// Top level: ready queue memory, scan/compact sequencer and result register.
//
//   channel   | handshake           | fields
//   ----------+---------------------+-----------------------------------------------
//   request   | start & !busy       | req_type, target_kind, target_tid
//   result    | done (one cycle)    | status, result_tid, running_tid, ready_count
//
// Requests that need no queue walk (errors, yield to self) give done the cycle
// after start and leave busy low. Create, and yield or destroy that target a
// queued entry, walk the queue once through the registered-read memory,
// compacting behind a removed entry; busy stays high until done. arst_n clears
// length and running id to 0; the queue memory is not cleared. The receiver
// cannot stall results.
module thread_ready_queue_scheduler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [1:0]           target_kind,
	input  logic [3:0]           target_tid,
	output logic                 done,
	output logic [1:0]           status,
	output logic [3:0]           result_tid,
	output logic [3:0]           running_tid,
	output logic [3:0]           ready_count
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t                          state_q;
	trqs_pkg::len_t                  len_q;
	trqs_pkg::tid_t                  cur_q;
	trqs_pkg::op_t                   op_q;
	trqs_pkg::tid_t                  tid_q;
	trqs_pkg::addr_t                 rd_idx_q;
	logic                            rd_v_s1;
	trqs_pkg::addr_t                 rd_idx_s1;
	trqs_pkg::tid_t                  rd_data_s1;
	logic                            found_q;
	trqs_pkg::tid_t                  found_id_q;
	logic [trqs_pkg::MAX_THREADS-1:0] taken_q;

	logic                            done_q;
	trqs_pkg::status_t               status_q;
	trqs_pkg::tid_t                  result_q;
	trqs_pkg::tid_t                  running_q;
	trqs_pkg::len_t                  count_q;

	trqs_pkg::tid_t                  mem [trqs_pkg::MAX_THREADS];
	logic                            mem_we;
	trqs_pkg::addr_t                 mem_waddr;
	trqs_pkg::tid_t                  mem_wdata;

	trqs_pkg::op_t                   op_dec;
	trqs_pkg::tid_t                  pick;
	logic                            accept;
	logic                            scan_issue;
	logic                            hit;

	trqs_decode u_decode (
		.req_type    (req_type),
		.target_kind (target_kind),
		.target_tid  (target_tid),
		.len         (len_q),
		.cur         (cur_q),
		.op          (op_dec)
	);

	trqs_pick u_pick (
		.taken (taken_q | (trqs_pkg::MAX_THREADS'(1) << cur_q)),
		.pick  (pick)
	);

	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign scan_issue  = (state_q == S_SCAN) && (trqs_pkg::len_t'(rd_idx_q) != len_q);
	assign hit         = op_q.match_head ? (rd_idx_s1 == '0) : (rd_data_s1 == tid_q);

	assign done        = done_q;
	assign status      = status_q;
	assign result_tid  = result_q;
	assign running_tid = running_q;
	assign ready_count = count_q;

	// single write port: compaction during the walk, tail append at the end
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1 - 1'b1;
		mem_wdata = rd_data_s1;
		if (state_q == S_SCAN) begin
			mem_we = rd_v_s1 && found_q && !op_q.create;
		end else if (state_q == S_FIN) begin
			if (op_q.create) begin
				mem_we    = 1'b1;
				mem_waddr = trqs_pkg::addr_t'(len_q);
				mem_wdata = pick;
			end else if (found_q && op_q.app_cur) begin
				mem_we    = 1'b1;
				mem_waddr = trqs_pkg::addr_t'(len_q - 1'b1);
				mem_wdata = cur_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			cur_q      <= '0;
			op_q       <= '0;
			tid_q      <= '0;
			rd_idx_q   <= '0;
			rd_v_s1    <= 1'b0;
			rd_idx_s1  <= '0;
			found_q    <= 1'b0;
			found_id_q <= '0;
			taken_q    <= '0;
			done_q     <= 1'b0;
			status_q   <= trqs_pkg::ST_OK;
			result_q   <= '0;
			running_q  <= '0;
			count_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					rd_v_s1 <= 1'b0;
					if (accept) begin
						op_q     <= op_dec;
						tid_q    <= target_tid;
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						taken_q  <= '0;
						if (op_dec.imm) begin
							done_q    <= 1'b1;
							status_q  <= op_dec.imm_status;
							result_q  <= op_dec.imm_result;
							running_q <= cur_q;
							count_q   <= len_q;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_v_s1   <= scan_issue;
					rd_idx_s1 <= rd_idx_q;
					if (scan_issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (rd_v_s1) begin
						taken_q <= taken_q | (trqs_pkg::MAX_THREADS'(1) << rd_data_s1);
						if (hit && !found_q) begin
							found_q    <= 1'b1;
							found_id_q <= rd_data_s1;
						end
					end
					if (!scan_issue && !rd_v_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (op_q.create) begin
						status_q  <= trqs_pkg::ST_OK;
						result_q  <= pick;
						running_q <= cur_q;
						count_q   <= len_q + 1'b1;
						len_q     <= len_q + 1'b1;
					end else if (!found_q) begin
						status_q  <= trqs_pkg::ST_INVALID;
						result_q  <= '0;
						running_q <= cur_q;
						count_q   <= len_q;
					end else begin
						status_q <= trqs_pkg::ST_OK;
						result_q <= op_q.res_cur ? cur_q : found_id_q;
						if (op_q.set_cur) begin
							cur_q     <= found_id_q;
							running_q <= found_id_q;
						end else begin
							running_q <= cur_q;
						end
						// yield keeps the length: the old running id takes the freed slot
						if (op_q.app_cur) begin
							count_q <= len_q;
						end else begin
							len_q   <= len_q - 1'b1;
							count_q <= len_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// no read in flight outside the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SCAN) |-> !scan_issue)
		else $error("queue read issued outside the walk");

	// compaction writes only follow the removed entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == S_SCAN) |-> (found_q && !op_q.create))
		else $error("queue write before a match");

	// queue length moves only when a walk completes
	assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != $past(len_q)) |-> ($past(state_q) == S_FIN))
		else $error("queue length changed outside completion");

	// a walk always ends in a result strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (done_q && state_q == S_IDLE))
		else $error("walk finished without a result");

	// a request that needs the queue raises busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !op_dec.imm) |=> busy)
		else $error("queue request accepted without busy");

endmodule

// ----- tb/sv/thread_ready_queue_scheduler_tb.sv -----
// Self-checking testbench for the thread ready queue scheduler.
`timescale 1ns / 100ps

module thread_ready_queue_scheduler_tb;

	localparam logic [1:0] REQ_BAD   = 2'd3;
	localparam logic [1:0] KIND_BAD  = 2'd3;
	localparam int DRAIN_CYCLES      = 25;
	localparam int CYCLE_LIMIT       = 200000;
	localparam int RANDOM_ITEMS      = 1050;
	localparam int PHASE_ITEMS       = 30;

	typedef struct {
		trqs_pkg::status_t st;
		trqs_pkg::tid_t    rtid;
		trqs_pkg::tid_t    run;
		trqs_pkg::tid_t    cnt;
	} sched_result_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] req_type;
	logic [1:0] target_kind;
	logic [3:0] target_tid;
	logic       done;
	logic [1:0] status;
	logic [3:0] result_tid;
	logic [3:0] running_tid;
	logic [3:0] ready_count;

	// scheduler state as predicted
	trqs_pkg::tid_t ready_model[$];
	trqs_pkg::tid_t running_model;
	sched_result_t  pending_results[$];
	sched_result_t  oldest;
	int             errors;
	int             cycle_count;

	thread_ready_queue_scheduler dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.target_kind(target_kind),
		.target_tid (target_tid),
		.done       (done),
		.status     (status),
		.result_tid (result_tid),
		.running_tid(running_tid),
		.ready_count(ready_count)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int queue_pos(trqs_pkg::tid_t id);
		int pos;
		pos = -1;
		foreach (ready_model[i])
			if (pos < 0 && ready_model[i] == id)
				pos = i;
		return pos;
	endfunction

	// Updates the predicted state for one request and returns its result.
	function automatic sched_result_t apply_request(logic [1:0] rq, logic [1:0] kd,
		trqs_pkg::tid_t tg);
		sched_result_t res;
		int pos;
		trqs_pkg::tid_t pick;
		trqs_pkg::tid_t nxt;
		res.st = trqs_pkg::ST_OK;
		res.rtid = '0;
		if (rq == trqs_pkg::REQ_CREATE) begin
			if (ready_model.size() + 1 >= trqs_pkg::MAX_THREADS) begin
				res.st = trqs_pkg::ST_NOMORE;
			end else begin
				// lowest free id wins; 0 only when every other id is taken
				pick = '0;
				for (int id = trqs_pkg::MAX_THREADS - 1; id >= 1; id--)
					if (trqs_pkg::tid_t'(id) != running_model
						&& queue_pos(trqs_pkg::tid_t'(id)) < 0)
						pick = trqs_pkg::tid_t'(id);
				ready_model.push_back(pick);
				res.rtid = pick;
			end
		end else if (rq == REQ_BAD || kd == KIND_BAD) begin
			res.st = trqs_pkg::ST_INVALID;
		end else if (kd != trqs_pkg::KIND_NAMED && ready_model.size() == 0) begin
			res.st = trqs_pkg::ST_NONE;
		end else if (rq == trqs_pkg::REQ_YIELD) begin
			if (kd == trqs_pkg::KIND_SELF
				|| (kd == trqs_pkg::KIND_NAMED && tg == running_model)) begin
				res.rtid = running_model;
			end else begin
				pos = (kd == trqs_pkg::KIND_ANY) ? 0 : queue_pos(tg);
				if (pos < 0) begin
					res.st = trqs_pkg::ST_INVALID;
				end else begin
					nxt = ready_model[pos];
					ready_model.delete(pos);
					ready_model.push_back(running_model);
					running_model = nxt;
					res.rtid = nxt;
				end
			end
		end else begin
			// destroy: the running id is never found among the queued ones
			pos = (kd == trqs_pkg::KIND_NAMED) ? queue_pos(tg) : 0;
			if (pos < 0) begin
				res.st = trqs_pkg::ST_INVALID;
			end else begin
				nxt = ready_model[pos];
				ready_model.delete(pos);
				res.rtid = (kd == trqs_pkg::KIND_SELF) ? running_model : nxt;
				if (kd == trqs_pkg::KIND_SELF)
					running_model = nxt;
			end
		end
		res.run = running_model;
		res.cnt = trqs_pkg::tid_t'(ready_model.size());
		return res;
	endfunction

	// Called at a falling edge; leaves start high so a back-to-back transaction keeps it up.
	task automatic send_request(logic [1:0] rq, logic [1:0] kd, trqs_pkg::tid_t tg, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start       <= 1'b1;
		req_type    <= rq;
		target_kind <= kd;
		target_tid  <= tg;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_results.push_back(apply_request(rq, kd, tg));
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d tid %0d",
					$time, status, result_tid);
				errors++;
			end else begin
				oldest = pending_results.pop_front();
				if (status !== oldest.st) begin
					$display("%0t: status expected %0d got %0d", $time, oldest.st, status);
					errors++;
				end
				if (result_tid !== oldest.rtid) begin
					$display("%0t: result_tid expected %0d got %0d", $time, oldest.rtid,
						result_tid);
					errors++;
				end
				if (running_tid !== oldest.run) begin
					$display("%0t: running_tid expected %0d got %0d", $time, oldest.run,
						running_tid);
					errors++;
				end
				if (ready_count !== oldest.cnt) begin
					$display("%0t: ready_count expected %0d got %0d", $time, oldest.cnt,
						ready_count);
					errors++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic test_empty_queue();
		send_request(trqs_pkg::REQ_YIELD, trqs_pkg::KIND_ANY, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_YIELD, trqs_pkg::KIND_SELF, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_DESTROY, trqs_pkg::KIND_ANY, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_DESTROY, trqs_pkg::KIND_SELF, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_YIELD, trqs_pkg::KIND_NAMED, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_DESTROY, trqs_pkg::KIND_NAMED, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_YIELD, trqs_pkg::KIND_NAMED, 4'd15, $urandom_range(3));
		send_request(REQ_BAD, KIND_BAD, 4'd15, $urandom_range(3));
		send_request(trqs_pkg::REQ_YIELD, KIND_BAD, 4'd7, $urandom_range(3));
	endtask

	task automatic test_basic_ops();
		// create ignores the target fields, even an illegal kind
		send_request(trqs_pkg::REQ_CREATE, KIND_BAD, 4'd15, $urandom_range(3));
		send_request(trqs_pkg::REQ_CREATE, trqs_pkg::KIND_ANY, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_CREATE, trqs_pkg::KIND_SELF, 4'd9, $urandom_range(3));
		send_request(trqs_pkg::REQ_YIELD, trqs_pkg::KIND_ANY, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_YIELD, trqs_pkg::KIND_NAMED, 4'd3, $urandom_range(3));
		send_request(trqs_pkg::REQ_YIELD, trqs_pkg::KIND_SELF, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_YIELD, trqs_pkg::KIND_NAMED, 4'd3, $urandom_range(3));
		send_request(trqs_pkg::REQ_DESTROY, trqs_pkg::KIND_NAMED, 4'd3, $urandom_range(3));
		send_request(trqs_pkg::REQ_DESTROY, trqs_pkg::KIND_NAMED, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_DESTROY, trqs_pkg::KIND_SELF, 4'd0, $urandom_range(3));
		send_request(trqs_pkg::REQ_DESTROY, trqs_pkg::KIND_ANY, 4'd0, $urandom_range(3));
	endtask

	// Fills the queue until every nonzero id is taken, then past full.
	task automatic test_full_queue();
		repeat (trqs_pkg::MAX_THREADS)
			send_request(trqs_pkg::REQ_CREATE, 2'($urandom_range(3)), 4'($urandom_range(15)),
				$urandom_range(3));
	endtask

	task automatic test_random(int n_items);
		int issued;
		int create_w;
		int r;
		bit quiet;
		logic [1:0] rq;
		logic [1:0] kd;
		trqs_pkg::tid_t tg;
		issued = 0;
		create_w = 40;
		quiet = 1'b0;
		while (issued < n_items) begin
			if (issued % PHASE_ITEMS == 0) begin
				// each phase leans toward filling, churning or draining the queue
				r = $urandom_range(2);
				create_w = (r == 0) ? 15 : (r == 1) ? 40 : 75;
				quiet = ($urandom_range(3) == 0);
			end
			r = $urandom_range(99);
			tg = 4'($urandom_range(15));
			if (r < 5) begin
				rq = 2'($urandom_range(3));
				kd = 2'($urandom_range(3));
			end else if (r < 5 + create_w) begin
				rq = trqs_pkg::REQ_CREATE;
				kd = 2'($urandom_range(3));
			end else begin
				rq = $urandom_range(1) ? trqs_pkg::REQ_YIELD : trqs_pkg::REQ_DESTROY;
				r = $urandom_range(9);
				kd = (r < 5) ? trqs_pkg::KIND_NAMED : (r < 8) ? trqs_pkg::KIND_ANY
					: trqs_pkg::KIND_SELF;
				r = $urandom_range(99);
				if (r < 60 && ready_model.size() > 0)
					tg = ready_model[$urandom_range(ready_model.size() - 1)];
				else if (r < 75)
					tg = running_model;
			end
			send_request(rq, kd, tg, quiet ? 0 : $urandom_range(3));
			issued++;
		end
	endtask

	initial begin
		errors        = 0;
		running_model = '0;
		arst_n        = 1'b0;
		start         = 1'b0;
		req_type      = trqs_pkg::REQ_CREATE;
		target_kind   = trqs_pkg::KIND_NAMED;
		target_tid    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_queue();
		test_basic_ops();
		test_full_queue();
		test_random(RANDOM_ITEMS);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- thread_ready_queue_scheduler.f -----
rtl/trqs_pkg.sv
rtl/trqs_decode.sv
rtl/trqs_pick.sv
rtl/thread_ready_queue_scheduler.sv
tb/sv/thread_ready_queue_scheduler_tb.sv
